// File: hdl/top_k_field_magnitude_select_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the top-k field magnitude selector
// Shared forms for the concurrent checks, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef TOP_K_FIELD_MAGNITUDE_SELECT_UNIT_DEFINES_SVH
`define TOP_K_FIELD_MAGNITUDE_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TKFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TKFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tkfm_pkg.sv
// ----------------------------------------------------------------------------
// tkfm_pkg
// Types, widths and helpers shared by the top-k field magnitude selector.
// ----------------------------------------------------------------------------
package tkfm_pkg;

    localparam int MAX_PICKS  = 16;
    localparam int SLOT_BITS  = $clog2(MAX_PICKS);
    localparam int KCNT_BITS  = 5;
    localparam int COMP_BITS  = 16;
    localparam int NUM_COMP   = 6;
    localparam int STEP_BITS  = 3;
    localparam int PROD_BITS  = 2 * COMP_BITS;
    localparam int MAG_BITS   = 33;
    localparam int INDEX_BITS = 24;
    localparam int POS_BITS   = 32;

    typedef logic [COMP_BITS-1:0]              t_comp;
    typedef t_comp [NUM_COMP-1:0]              t_comp_vec;

    typedef struct packed {
        logic [MAG_BITS-1:0]   mag;
        logic [INDEX_BITS-1:0] idx;
        logic [POS_BITS-1:0]   px;
        logic [POS_BITS-1:0]   py;
        logic [POS_BITS-1:0]   pz;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_SCAN,
        ST_ERD,
        ST_EOUT
    } t_state;

    // Effective keep count: zero acts as one, anything above the window depth
    // acts as the full depth.
    function automatic logic [KCNT_BITS-1:0] eff_k(input logic [KCNT_BITS-1:0] v);
        logic [KCNT_BITS-1:0] k;
        k = v;
        if (v == '0) begin
            k = KCNT_BITS'(1);
        end else if (v > KCNT_BITS'(MAX_PICKS)) begin
            k = KCNT_BITS'(MAX_PICKS);
        end
        return k;
    endfunction

endpackage

// File: hdl/top_k_field_magnitude_select_unit.sv
// ----------------------------------------------------------------------------
// top_k_field_magnitude_select_unit
// Keeps the keep_count largest field points of a set and reports them sorted.
// ----------------------------------------------------------------------------
// Each transaction runs the magnitude (one multiplier, six components) and
// then the insertion walk, which visits one slot position at a time. A new
// point is taken only in idle, once the last one is through.
// With end_of_set the K slots then leave in rank order, each read from the
// slot store (one read port) before it is loaded, while the output keeps up.
// Reset is synchronous: keep_count goes to 16, the window to empty and the
// arrival counter to zero. The slot store itself is not cleared.
// ----------------------------------------------------------------------------
`include "top_k_field_magnitude_select_unit_defines.svh"

module top_k_field_magnitude_select_unit
    import tkfm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [KCNT_BITS-1:0]         i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COMP_BITS-1:0]  i_ex,
    input  logic signed [COMP_BITS-1:0]  i_ey,
    input  logic signed [COMP_BITS-1:0]  i_ez,
    input  logic signed [COMP_BITS-1:0]  i_hx,
    input  logic signed [COMP_BITS-1:0]  i_hy,
    input  logic signed [COMP_BITS-1:0]  i_hz,
    input  logic signed [POS_BITS-1:0]   i_pos_x,
    input  logic signed [POS_BITS-1:0]   i_pos_y,
    input  logic signed [POS_BITS-1:0]   i_pos_z,
    input  logic                         i_end_of_set,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [SLOT_BITS-1:0]         o_rank,
    output logic                         o_slot_filled,
    output logic [INDEX_BITS-1:0]        o_point_index,
    output logic [MAG_BITS-1:0]          o_magnitude_sq,
    output logic signed [POS_BITS-1:0]   o_out_x,
    output logic signed [POS_BITS-1:0]   o_out_y,
    output logic signed [POS_BITS-1:0]   o_out_z,
    output logic                         o_last_result
);

    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

    t_state                 r_state, n_state;
    logic [KCNT_BITS-1:0]   r_k;
    logic [KCNT_BITS-1:0]   r_fs, n_fs;
    logic [KCNT_BITS-1:0]   r_idx, n_idx;
    logic [INDEX_BITS-1:0]  r_cnt;
    t_comp_vec              r_comp;
    t_slot                  r_new;
    logic                   r_eos;
    logic                   r_out_valid;
    t_slot                  r_out;
    logic [SLOT_BITS-1:0]   r_out_rank;
    logic                   r_out_filled;
    logic                   r_out_last;

    logic                   in_acc;
    logic                   mag_start, mag_done;
    logic [MAG_BITS-1:0]    mag;
    logic                   ram_we;
    logic [SLOT_BITS-1:0]   ram_wa, ram_ra;
    t_slot                  ram_wd, ram_rd;
    logic                   out_load;
    logic                   set_done;
    logic                   greater;
    logic                   cur_filled;
    logic                   cur_last;

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;

    tkfm_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mag_start),
        .i_comp  (r_comp),
        .o_done  (mag_done),
        .o_mag   (mag)
    );

    tkfm_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    // The walk starts at the smallest kept slot; while the new point is larger
    // each kept entry moves one slot down, the one in slot zero falling out.
    assign greater    = (r_idx != r_k) && (mag > ram_rd.mag);
    assign cur_filled = (r_idx >= r_fs);
    assign cur_last   = (r_idx == r_k - KCNT_BITS'(1));

    always_comb begin
        n_state   = r_state;
        n_fs      = r_fs;
        n_idx     = r_idx;
        mag_start = 1'b0;
        ram_we    = 1'b0;
        ram_wa    = SLOT_BITS'(r_idx - KCNT_BITS'(1));
        ram_wd    = ram_rd;
        ram_ra    = r_idx[SLOT_BITS-1:0];
        out_load  = 1'b0;
        set_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    mag_start = 1'b1;
                    n_state   = ST_MAG;
                end
            end
            ST_MAG: begin
                ram_ra = r_fs[SLOT_BITS-1:0];
                if (mag_done) begin
                    n_idx   = r_fs;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (greater) begin
                    ram_we = (r_idx != '0);
                    n_idx  = r_idx + KCNT_BITS'(1);
                    ram_ra = n_idx[SLOT_BITS-1:0];
                end else begin
                    ram_we = (r_idx != '0);
                    ram_wd = r_new;
                    ram_wd.mag = mag;
                    n_fs   = (r_fs == '0) ? '0 : r_fs - KCNT_BITS'(1);
                    n_idx  = '0;
                    n_state = r_eos ? ST_ERD : ST_IDLE;
                end
            end
            ST_ERD: begin
                n_state = ST_EOUT;
            end
            ST_EOUT: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    if (cur_last) begin
                        set_done = 1'b1;
                        n_fs     = r_k;
                        n_idx    = '0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + KCNT_BITS'(1);
                        n_state = ST_ERD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= KCNT_BITS'(MAX_PICKS);
            r_fs        <= KCNT_BITS'(MAX_PICKS);
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_k   <= eff_k(i_cfg_data);
                r_fs  <= eff_k(i_cfg_data);
                r_cnt <= '0;
            end else begin
                r_fs <= n_fs;
                if (set_done) begin
                    r_cnt <= '0;
                end else if (in_acc && (r_cnt != IDX_MAX)) begin
                    r_cnt <= r_cnt + INDEX_BITS'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured transaction and the output register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_comp  <= {i_hz, i_hy, i_hx, i_ez, i_ey, i_ex};
            r_new   <= '{mag: '0, idx: r_cnt, px: i_pos_x, py: i_pos_y, pz: i_pos_z};
            r_eos   <= i_end_of_set;
        end
        if (out_load) begin
            r_out_rank   <= r_idx[SLOT_BITS-1:0];
            r_out_filled <= cur_filled;
            r_out_last   <= cur_last;
            r_out        <= cur_filled ? ram_rd : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rank         = r_out_rank;
    assign o_slot_filled  = r_out_filled;
    assign o_point_index  = r_out.idx;
    assign o_magnitude_sq = r_out.mag;
    assign o_out_x        = r_out.px;
    assign o_out_y        = r_out.py;
    assign o_out_z        = r_out.pz;
    assign o_last_result  = r_out_last;

    `TKFM_ASSERT_NOW(a_fs_in_window, 1'b1, r_fs <= r_k, "fill start beyond keep count")
    `TKFM_ASSERT_NOW(a_write_in_window, ram_we, KCNT_BITS'(ram_wa) < r_k, "write outside window")
    `TKFM_ASSERT_NOW(a_scan_bound, r_state == ST_SCAN, r_idx <= r_k, "insertion walk overran")
    `TKFM_ASSERT_NEXT(a_clear_after_set, set_done, r_fs == r_k, "window not cleared after set")

endmodule

// File: hdl/tkfm_mag.sv
// ----------------------------------------------------------------------------
// tkfm_mag
// Squared field magnitude, one shared multiplier stepped over six components.
// ----------------------------------------------------------------------------
module tkfm_mag
    import tkfm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_comp_vec           i_comp,
    output logic                o_done,
    output logic [MAG_BITS-1:0] o_mag
);

    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(NUM_COMP);

    logic                  r_busy;
    logic [STEP_BITS-1:0]  r_step;
    logic [PROD_BITS-1:0]  r_prod;
    logic [MAG_BITS-1:0]   r_acc;
    t_comp                 sel;

    always_comb begin
        sel = '0;
        if (r_step < STEP_LAST) begin
            sel = i_comp[r_step];
        end
    end

    assign o_done = r_busy && (r_step == STEP_LAST);
    assign o_mag  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_BITS'(1);
            if (r_step == STEP_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The product of a component with itself is never negative, so it is kept
    // unsigned; the accumulator picks it up from the product register in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_prod <= PROD_BITS'($signed(sel) * $signed(sel));
            if (r_step != '0) begin
                r_acc <= r_acc + MAG_BITS'(r_prod);
            end
        end
    end

endmodule

// File: hdl/tkfm_ram.sv
// ----------------------------------------------------------------------------
// tkfm_ram
// Slot store of the sorted window: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module tkfm_ram
    import tkfm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [SLOT_BITS-1:0] i_waddr,
    input  t_slot                i_wdata,
    input  logic [SLOT_BITS-1:0] i_raddr,
    output t_slot                o_rdata
);

    t_slot mem [MAX_PICKS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
